/* hdl/sha1_pkg.sv */
`default_nettype none

package sha1_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAIN_WORDS = 5;
    localparam int CHAIN_AW    = 3;
    localparam int BUF_WORDS   = 16;
    localparam int BUF_AW      = 4;
    localparam int ROUNDS      = 80;
    localparam int RND_W       = 7;

    // request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_WBACK,
        ST_PAD,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } sha1_state_t;

    // byte write into the block buffer
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [1:0]        lane;
        logic [7:0]        data;
    } buf_wr_t;

    // word write into the chaining store
    typedef struct packed {
        logic                we;
        logic [CHAIN_AW-1:0] addr;
        logic [WORD_W-1:0]   data;
    } chain_wr_t;

    // sequencing of the round datapath
    typedef struct packed {
        logic                sched_shift;
        logic                var_load;
        logic [CHAIN_AW-1:0] var_idx;
        logic                round_en;
        logic [RND_W-1:0]    round_idx;
        logic [CHAIN_AW-1:0] wb_idx;
    } core_ctrl_t;

    function automatic logic [WORD_W-1:0] sha1_iv(input logic [CHAIN_AW-1:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] sha1_k(input logic [RND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        if (rnd < 7'd20)
            k = 32'h5A827999;
        else if (rnd < 7'd40)
            k = 32'h6ED9EBA1;
        else if (rnd < 7'd60)
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] sha1_f(input logic [RND_W-1:0] rnd,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] f;
        if (rnd < 7'd20)
            f = (b & c) | (~b & d);
        else if (rnd < 7'd40)
            f = b ^ c ^ d;
        else if (rnd < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

`default_nettype wire

/* hdl/sha1_buf_ram.sv */
`default_nettype none

module sha1_buf_ram
    import sha1_pkg::*;
(
    input  wire logic              clk,
    input  wire buf_wr_t           wr,
    input  wire logic [BUF_AW-1:0] raddr,
    output logic [WORD_W-1:0]      rdata
);

    // 16 big-endian words, byte lane 0 is the most significant byte
    logic [WORD_W-1:0] mem [0:BUF_WORDS-1];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr][8*(3 - int'(wr.lane)) +: 8] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/sha1_chain_ram.sv */
`default_nettype none

module sha1_chain_ram
    import sha1_pkg::*;
(
    input  wire logic                clk,
    input  wire chain_wr_t           wr,
    input  wire logic [CHAIN_AW-1:0] raddr,
    output logic [WORD_W-1:0]        rdata
);

    logic [WORD_W-1:0] mem [0:CHAIN_WORDS-1];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/sha1_round_core.sv */
`default_nettype none

module sha1_round_core
    import sha1_pkg::*;
(
    input  wire logic              clk,
    input  wire core_ctrl_t        ctrl,
    input  wire logic [WORD_W-1:0] buf_rdata,
    input  wire logic [WORD_W-1:0] chain_rdata,
    output logic [WORD_W-1:0]      wb_sum
);

    // schedule window: sched_reg[i] holds w[t+i]
    logic [WORD_W-1:0] sched_reg [0:BUF_WORDS-1];
    // working variables a..e and the chaining words they started from
    logic [WORD_W-1:0] wv_reg [0:CHAIN_WORDS-1];
    logic [WORD_W-1:0] hv_reg [0:CHAIN_WORDS-1];

    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] w_new;
    logic [WORD_W-1:0] t_sum;

    always_comb
    begin
        mix   = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new = {mix[WORD_W-2:0], mix[WORD_W-1]};
        t_sum = {wv_reg[0][WORD_W-6:0], wv_reg[0][WORD_W-1:WORD_W-5]}
              + sha1_f(ctrl.round_idx, wv_reg[1], wv_reg[2], wv_reg[3])
              + wv_reg[4] + sched_reg[0] + sha1_k(ctrl.round_idx);
        wb_sum = hv_reg[ctrl.wb_idx] + wv_reg[ctrl.wb_idx];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sched_shift || ctrl.round_en)
        begin
            for (int i = 0; i < BUF_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BUF_WORDS-1] <= ctrl.round_en ? w_new : buf_rdata;
        end

        if (ctrl.var_load)
        begin
            wv_reg[ctrl.var_idx] <= chain_rdata;
            hv_reg[ctrl.var_idx] <= chain_rdata;
        end
        else if (ctrl.round_en)
        begin
            wv_reg[0] <= t_sum;
            wv_reg[1] <= wv_reg[0];
            wv_reg[2] <= {wv_reg[1][1:0], wv_reg[1][WORD_W-1:2]};
            wv_reg[3] <= wv_reg[2];
            wv_reg[4] <= wv_reg[3];
        end
    end

endmodule

`default_nettype wire

/* hdl/sha1_message_hasher.sv */
// sha-1 hasher over a byte stream, 160-bit digest
//
// input channel (in_valid / in_ready): one byte or command per request, req_type selects
// start (load initial chaining words, clear bit count and finished mark),
// data (append data_byte) or finish (pad, close and emit the digest).
// data and finish requests after the digest has been emitted are dropped
// until the next start; code 3 is dropped always.
//
// output channel (out_valid / out_ready): five digest words, word_index 0..4,
// most significant first, last_word set on index 4. a single output register
// separates the sides; while the receiver stalls the emit sequencer waits
// and the held word stays unchanged.
//
// flow: each data byte is written into the block buffer. every 64th byte starts
// a block compression (load buffer and chaining words, 80 rounds, 5 write-backs)
// on the single-round datapath; no request is taken until it is through.
// finish writes padding bytes up to the end of the block (and a whole second
// block when the length does not fit), runs one compression per padded block,
// then emits the digest words. a start writes the initial words into the
// chaining store; after reset the same pass runs before any request is taken.
`default_nettype none

module sha1_message_hasher
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sha1_state_t state_reg, state_next;

    logic [RND_W-1:0]    cnt_reg, cnt_next;
    logic [63:0]         bit_count_reg, bit_count_next;
    logic                finished_reg, finished_next;
    logic                fin_reg, fin_next;         // compression belongs to a finish
    logic                final_reg, final_next;     // padded block carries the length
    logic                mark_reg, mark_next;       // next pad byte is the 0x80 mark
    logic [5:0]          ptr_reg, ptr_next;         // pad byte position
    logic [CHAIN_AW-1:0] emit_idx_reg, emit_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_word_reg;
    logic [2:0]          out_idx_reg;
    logic                out_last_reg;

    logic                in_fire;
    logic                slot_free;
    logic                out_load;
    logic [5:0]          pos;
    logic [63:0]         len_shift;
    logic [7:0]          pad_byte;

    buf_wr_t             buf_wr;
    chain_wr_t           chain_wr;
    core_ctrl_t          core_ctrl;
    logic [BUF_AW-1:0]   buf_raddr;
    logic [CHAIN_AW-1:0] chain_raddr;
    logic [WORD_W-1:0]   buf_rdata;
    logic [WORD_W-1:0]   chain_rdata;
    logic [WORD_W-1:0]   wb_sum;

    assign pos       = bit_count_reg[8:3];
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // length bytes go out big-endian at buffer positions 56..63
    assign len_shift = bit_count_reg >> {~ptr_reg[2:0], 3'b000};
    assign pad_byte  = mark_reg ? PAD_MARK
                     : (final_reg && ptr_reg >= 6'd56) ? len_shift[7:0] : 8'h00;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (cnt_reg == RND_W'(CHAIN_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type)
                        REQ_START:
                            state_next = ST_INIT;
                        REQ_DATA:
                        begin
                            if (!finished_reg && pos == 6'd63)
                                state_next = ST_LOAD;
                        end
                        REQ_FINISH:
                        begin
                            if (!finished_reg)
                                state_next = ST_PAD;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == RND_W'(BUF_WORDS))
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (cnt_reg == RND_W'(ROUNDS - 1))
                    state_next = ST_WBACK;
            end
            ST_WBACK:
            begin
                if (cnt_reg == RND_W'(CHAIN_WORDS - 1))
                begin
                    if (!fin_reg)
                        state_next = ST_IDLE;
                    else if (final_reg)
                        state_next = ST_EMIT_RD;
                    else
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (ptr_reg == 6'd63)
                    state_next = ST_LOAD;
            end
            ST_EMIT_RD:
                state_next = ST_EMIT_CAP;
            ST_EMIT_CAP:
            begin
                if (slot_free)
                    state_next = (emit_idx_reg == CHAIN_AW'(CHAIN_WORDS - 1)) ? ST_IDLE
                                                                            : ST_EMIT_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: memory ports and datapath control
    always_comb
    begin
        in_ready    = 1'b0;
        buf_wr      = '0;
        chain_wr    = '0;
        core_ctrl   = '0;
        buf_raddr   = '0;
        chain_raddr = '0;
        out_load    = 1'b0;
        core_ctrl.wb_idx = cnt_reg[CHAIN_AW-1:0];
        case (state_reg)
            ST_INIT:
            begin
                chain_wr.we   = 1'b1;
                chain_wr.addr = cnt_reg[CHAIN_AW-1:0];
                chain_wr.data = sha1_iv(cnt_reg[CHAIN_AW-1:0]);
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                buf_wr.we    = in_fire && req_type == REQ_DATA && !finished_reg;
                buf_wr.addr  = pos[5:2];
                buf_wr.lane  = pos[1:0];
                buf_wr.data  = data_byte;
            end
            ST_LOAD:
            begin
                // read data lands in the cycle after its address
                buf_raddr = cnt_reg[BUF_AW-1:0];
                if (cnt_reg < RND_W'(CHAIN_WORDS))
                    chain_raddr = cnt_reg[CHAIN_AW-1:0];
                core_ctrl.sched_shift = cnt_reg != '0;
                core_ctrl.var_load    = cnt_reg != '0 && cnt_reg <= RND_W'(CHAIN_WORDS);
                core_ctrl.var_idx     = cnt_reg[CHAIN_AW-1:0] - CHAIN_AW'(1);
            end
            ST_ROUND:
            begin
                core_ctrl.round_en  = 1'b1;
                core_ctrl.round_idx = cnt_reg;
            end
            ST_WBACK:
            begin
                chain_wr.we   = 1'b1;
                chain_wr.addr = cnt_reg[CHAIN_AW-1:0];
                chain_wr.data = wb_sum;
            end
            ST_PAD:
            begin
                buf_wr.we   = 1'b1;
                buf_wr.addr = ptr_reg[5:2];
                buf_wr.lane = ptr_reg[1:0];
                buf_wr.data = pad_byte;
            end
            ST_EMIT_RD:
                chain_raddr = emit_idx_reg;
            ST_EMIT_CAP:
            begin
                chain_raddr = emit_idx_reg;
                out_load    = slot_free;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    // register next values
    always_comb
    begin
        bit_count_next = bit_count_reg;
        finished_next  = finished_reg;
        fin_next       = fin_reg;
        final_next     = final_reg;
        mark_next      = mark_reg;
        ptr_next       = ptr_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;

        if (state_next != state_reg)
            cnt_next = '0;
        else if (state_reg == ST_INIT || state_reg == ST_LOAD ||
                 state_reg == ST_ROUND || state_reg == ST_WBACK)
            cnt_next = cnt_reg + RND_W'(1);
        else
            cnt_next = '0;

        if (in_fire)
        begin
            case (req_type)
                REQ_START:
                begin
                    bit_count_next = '0;
                    finished_next  = 1'b0;
                end
                REQ_DATA:
                begin
                    if (!finished_reg)
                    begin
                        bit_count_next = bit_count_reg + 64'd8;
                        fin_next       = 1'b0;
                    end
                end
                REQ_FINISH:
                begin
                    if (!finished_reg)
                    begin
                        finished_next = 1'b1;
                        fin_next      = 1'b1;
                        mark_next     = 1'b1;
                        ptr_next      = pos;
                        final_next    = pos < 6'd56;
                        emit_idx_next = '0;
                    end
                end
                default:
                    fin_next = fin_reg;
            endcase
        end

        if (state_reg == ST_PAD)
        begin
            mark_next = 1'b0;
            ptr_next  = ptr_reg + 6'd1;
        end

        // the length block follows a block that could not hold it
        if (state_reg == ST_WBACK && state_next == ST_PAD)
            final_next = 1'b1;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            emit_idx_next  = emit_idx_reg + CHAIN_AW'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            bit_count_reg <= '0;
            finished_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            final_reg     <= 1'b0;
            mark_reg      <= 1'b0;
            ptr_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bit_count_reg <= bit_count_next;
            finished_reg  <= finished_next;
            fin_reg       <= fin_next;
            final_reg     <= final_next;
            mark_reg      <= mark_next;
            ptr_reg       <= ptr_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= chain_rdata;
            out_idx_reg  <= emit_idx_reg;
            out_last_reg <= emit_idx_reg == CHAIN_AW'(CHAIN_WORDS - 1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_idx_reg;
    assign last_word   = out_last_reg;

    sha1_buf_ram u_buf (
        .clk   (clk),
        .wr    (buf_wr),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    sha1_chain_ram u_chain (
        .clk   (clk),
        .wr    (chain_wr),
        .raddr (chain_raddr),
        .rdata (chain_rdata)
    );

    sha1_round_core u_core (
        .clk         (clk),
        .ctrl        (core_ctrl),
        .buf_rdata   (buf_rdata),
        .chain_rdata (chain_rdata),
        .wb_sum      (wb_sum)
    );

endmodule

`default_nettype wire

/* hdl/sha1_checker.sv */
`default_nettype none

module sha1_checker
    import sha1_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  req_type,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) &&
                                    $stable(word_index) && $stable(last_word))
        else $error("stalled digest word changed");

    // last mark only on the fifth word
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd4)))
        else $error("last_word does not match word_index");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_index <= 3'd4)
        else $error("word_index out of range");

    // a start rewrites the chaining words before anything else is taken
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_START |=> !in_ready)
        else $error("request taken during chaining word init");

    // the digest goes out as one burst with requests held off
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && word_index < 3'd3 |=> !in_ready)
        else $error("request taken in the middle of a digest");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (.*);

`default_nettype wire
